// ===== rtl/core/acktq_pkg.sv =====
// Package for the acknowledged message queue: opcodes, entry states,
// result codes and field widths. Depends on nothing.
`default_nettype none
package acktq_pkg;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam int OP_W   = 3;
    localparam int ID_W   = 32;
    localparam int SIZE_W = 32;
    localparam int OFF_W  = 48;
    localparam int CODE_W = 2;
    localparam int ST_W   = 2;
    localparam int ENTRY_W = ST_W + OFF_W + SIZE_W;

    localparam logic [OP_W-1:0] OP_ENQ  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 3'd1;
    localparam logic [OP_W-1:0] OP_ACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_FACK = 3'd3;
    localparam logic [OP_W-1:0] OP_NACK = 3'd4;
    localparam logic [OP_W-1:0] OP_PURGE = 3'd5;

    localparam logic [ST_W-1:0] ST_READY = 2'd0;
    localparam logic [ST_W-1:0] ST_UNACK = 2'd1;
    localparam logic [ST_W-1:0] ST_ACK   = 2'd2;
    localparam logic [ST_W-1:0] ST_FACK  = 2'd3;

    localparam logic [CODE_W-1:0] RC_OK    = 2'd0;
    localparam logic [CODE_W-1:0] RC_FAIL  = 2'd1;
    localparam logic [CODE_W-1:0] RC_EMPTY = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/core/acktq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none
module acktq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/ack_tracking_message_queue.sv =====
// Acknowledged message queue, top level: sequencer, pointers and counters.
// Depends on acktq_pkg and acktq_ram.
//
// Usage: one command transaction on the s_ channel (opcode, msg_id, msg_size)
// gives exactly one result transaction on the m_ channel. Commands are taken
// one at a time. After acceptance the sequencer passes S_ISSUE, then S_PUSH,
// which registers the result and raises m_tvalid, for enqueue, an empty
// dequeue, an id outside the table, a purge with nothing to drop and an unknown
// opcode; it passes S_EXEC in between for nack, a purge that drops entries and
// any ack, failed ack or nack of an entry that is not unacknowledged. A dequeue,
// ack or failed ack that succeeds also runs its pointer scan through S_SRD and
// S_SCHK until it runs into the end of the table or stops on a held entry; the
// scan reads the entry table one slot at a time through its single read port.
// s_tready rises in the cycle in which the result appears, and the next
// command can be accepted from then on. A stalled receiver holds one finished
// result while the next command executes; after that the block stops accepting
// until m_tready. Reset (aresetn low, synchronous) empties the queue and all
// counters; the entry table is not cleared, since only held entries are read.
`default_nettype none
module ack_tracking_message_queue #(
    parameter int TABLE_DEPTH = acktq_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // opcode[2:0], msg_id[34:3], msg_size[66:35], zero fill
    input  wire logic [71:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_code[1:0], out_id[33:2], data_offset[81:34], data_length[113:82],
    // trimmed_bytes[161:114], pending_count[193:162], held_count[225:194], zero fill
    output logic [231:0]      m_tdata
);
    localparam int SW = $clog2(TABLE_DEPTH);
    localparam int IW = acktq_pkg::ID_W;
    localparam int OW = acktq_pkg::OFF_W;
    localparam int LW = acktq_pkg::SIZE_W;
    localparam int EW = acktq_pkg::ENTRY_W;
    localparam int CW = acktq_pkg::CODE_W;
    localparam logic [SW:0]   DEPTH_S = (SW+1)'(TABLE_DEPTH);
    localparam logic [SW-1:0] LAST_S  = SW'(TABLE_DEPTH - 1);
    localparam logic [IW-1:0] DEPTH_I = IW'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SRD   = 3'd3;
    localparam logic [2:0] S_SCHK  = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [acktq_pkg::OP_W-1:0] op_reg, op_next;
    logic [IW-1:0] id_reg, id_next;
    logic [LW-1:0] size_reg, size_next;
    logic scan_ack_reg, scan_ack_next;
    logic [SW-1:0] mslot_reg, mslot_next;

    logic [IW-1:0] next_id_reg, next_id_next, oldest_reg, oldest_next;
    logic [IW-1:0] rptr_reg, rptr_next, aptr_reg, aptr_next;
    logic [SW-1:0] nslot_reg, nslot_next, oslot_reg, oslot_next;
    logic [SW-1:0] rslot_reg, rslot_next, aslot_reg, aslot_next;
    logic [OW-1:0] dend_reg, dend_next, base_reg, base_next;
    logic [IW-1:0] held_reg, held_next, pend_reg, pend_next;
    logic [IW-1:0] ready_reg, ready_next, unack_reg, unack_next;

    logic [CW-1:0] code_reg, code_next;
    logic [IW-1:0] oid_reg, oid_next;
    logic [OW-1:0] off_reg, off_next, trim_reg, trim_next;
    logic [LW-1:0] len_reg, len_next;

    logic m_valid_reg, m_valid_next;
    logic [231:0] m_data_reg, m_data_next;

    logic wr_en;
    logic [SW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data, rd_data;
    logic [acktq_pkg::ST_W-1:0] rd_st;
    logic [OW-1:0] rd_off;
    logic [LW-1:0] rd_len;

    logic [IW-1:0] d_id, d_rptr, d_aptr;
    logic [SW:0] msum;

    acktq_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign rd_st  = rd_data[1:0];
    assign rd_off = rd_data[49:2];
    assign rd_len = rd_data[81:50];

    assign d_id   = id_reg - oldest_reg;
    assign d_rptr = rptr_reg - oldest_reg;
    assign d_aptr = aptr_reg - oldest_reg;
    assign msum   = {1'b0, oslot_reg} + {1'b0, d_id[SW-1:0]};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == LAST_S) ? '0 : s + SW'(1);
    endfunction

    always_comb begin
        state_next = state_reg;
        op_next = op_reg; id_next = id_reg; size_next = size_reg;
        scan_ack_next = scan_ack_reg; mslot_next = mslot_reg;
        next_id_next = next_id_reg; oldest_next = oldest_reg;
        rptr_next = rptr_reg; aptr_next = aptr_reg;
        nslot_next = nslot_reg; oslot_next = oslot_reg;
        rslot_next = rslot_reg; aslot_next = aslot_reg;
        dend_next = dend_reg; base_next = base_reg;
        held_next = held_reg; pend_next = pend_reg;
        ready_next = ready_reg; unack_next = unack_reg;
        code_next = code_reg; oid_next = oid_reg; off_next = off_reg;
        trim_next = trim_reg; len_next = len_reg;
        m_valid_next = m_valid_reg; m_data_next = m_data_reg;
        wr_en = 1'b0; wr_addr = nslot_reg; wr_data = {size_reg, dend_reg, acktq_pkg::ST_READY};
        rd_addr = rslot_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_tdata[2:0];
                    id_next   = s_tdata[34:3];
                    size_next = s_tdata[66:35];
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                code_next = acktq_pkg::RC_FAIL;
                oid_next = '0; off_next = '0; len_next = '0; trim_next = '0;
                state_next = S_PUSH;
                case (op_reg)
                    acktq_pkg::OP_ENQ: begin
                        if (held_reg < DEPTH_I) begin
                            wr_en = 1'b1;
                            oid_next = next_id_reg;
                            next_id_next = next_id_reg + IW'(1);
                            nslot_next = slot_inc(nslot_reg);
                            held_next = held_reg + IW'(1);
                            pend_next = pend_reg + IW'(1);
                            ready_next = ready_reg + IW'(1);
                            dend_next = dend_reg + OW'(size_reg);
                            code_next = acktq_pkg::RC_OK;
                        end
                    end
                    acktq_pkg::OP_DEQ: begin
                        if (d_rptr >= held_reg) begin
                            code_next = acktq_pkg::RC_EMPTY;
                        end else begin
                            rd_addr = rslot_reg;
                            state_next = S_EXEC;
                        end
                    end
                    acktq_pkg::OP_ACK, acktq_pkg::OP_FACK, acktq_pkg::OP_NACK: begin
                        if (d_id < held_reg) begin
                            mslot_next = (msum >= DEPTH_S) ? SW'(msum - DEPTH_S) : msum[SW-1:0];
                            rd_addr = mslot_next;
                            state_next = S_EXEC;
                        end
                    end
                    acktq_pkg::OP_PURGE: begin
                        code_next = acktq_pkg::RC_OK;
                        if (d_aptr < held_reg) begin
                            rd_addr = aslot_reg;
                            state_next = S_EXEC;
                        end
                    end
                    default: ;
                endcase
            end
            S_EXEC: begin
                state_next = S_PUSH;
                case (op_reg)
                    acktq_pkg::OP_DEQ: begin
                        wr_en = 1'b1;
                        wr_addr = rslot_reg;
                        wr_data = {rd_len, rd_off, acktq_pkg::ST_UNACK};
                        oid_next = rptr_reg;
                        off_next = rd_off - base_reg;
                        len_next = rd_len;
                        ready_next = ready_reg - IW'(1);
                        unack_next = unack_reg + IW'(1);
                        rptr_next = rptr_reg + IW'(1);
                        rslot_next = slot_inc(rslot_reg);
                        code_next = acktq_pkg::RC_OK;
                        scan_ack_next = 1'b0;
                        state_next = S_SRD;
                    end
                    acktq_pkg::OP_PURGE: begin
                        trim_next = rd_off - base_reg;
                        base_next = rd_off;
                        oldest_next = aptr_reg;
                        oslot_next = aslot_reg;
                        held_next = next_id_reg - aptr_reg;
                        pend_next = ready_reg + unack_reg;
                    end
                    default: begin
                        if (rd_st == acktq_pkg::ST_UNACK) begin
                            wr_en = 1'b1;
                            wr_addr = mslot_reg;
                            unack_next = unack_reg - IW'(1);
                            code_next = acktq_pkg::RC_OK;
                            if (op_reg == acktq_pkg::OP_NACK) begin
                                wr_data = {rd_len, rd_off, acktq_pkg::ST_READY};
                                ready_next = ready_reg + IW'(1);
                                if (d_id < d_rptr) begin
                                    rptr_next = id_reg;
                                    rslot_next = mslot_reg;
                                end
                            end else begin
                                wr_data = {rd_len, rd_off,
                                           (op_reg == acktq_pkg::OP_ACK) ?
                                           acktq_pkg::ST_ACK : acktq_pkg::ST_FACK};
                                pend_next = pend_reg - IW'(1);
                                scan_ack_next = 1'b1;
                                state_next = S_SRD;
                            end
                        end
                    end
                endcase
            end
            S_SRD: begin
                // The scan issues its read here; an entry written in S_EXEC is seen updated.
                if (scan_ack_reg) begin
                    rd_addr = aslot_reg;
                    state_next = (d_aptr < held_reg) ? S_SCHK : S_PUSH;
                end else begin
                    rd_addr = rslot_reg;
                    state_next = (d_rptr < held_reg) ? S_SCHK : S_PUSH;
                end
            end
            S_SCHK: begin
                state_next = S_PUSH;
                if (scan_ack_reg) begin
                    if (rd_st == acktq_pkg::ST_ACK || rd_st == acktq_pkg::ST_FACK) begin
                        aptr_next = aptr_reg + IW'(1);
                        aslot_next = slot_inc(aslot_reg);
                        state_next = S_SRD;
                    end
                end else if (rd_st != acktq_pkg::ST_READY) begin
                    rptr_next = rptr_reg + IW'(1);
                    rslot_next = slot_inc(rslot_reg);
                    state_next = S_SRD;
                end
            end
            S_PUSH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next = {6'd0, held_reg, pend_reg, trim_reg, len_reg,
                                   off_reg, oid_reg, code_reg};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            next_id_reg <= '0; oldest_reg <= '0; rptr_reg <= '0; aptr_reg <= '0;
            nslot_reg <= '0; oslot_reg <= '0; rslot_reg <= '0; aslot_reg <= '0;
            dend_reg <= '0; base_reg <= '0;
            held_reg <= '0; pend_reg <= '0; ready_reg <= '0; unack_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            next_id_reg <= next_id_next; oldest_reg <= oldest_next;
            rptr_reg <= rptr_next; aptr_reg <= aptr_next;
            nslot_reg <= nslot_next; oslot_reg <= oslot_next;
            rslot_reg <= rslot_next; aslot_reg <= aslot_next;
            dend_reg <= dend_next; base_reg <= base_next;
            held_reg <= held_next; pend_reg <= pend_next;
            ready_reg <= ready_next; unack_reg <= unack_next;
        end
        op_reg <= op_next; id_reg <= id_next; size_reg <= size_next;
        scan_ack_reg <= scan_ack_next; mslot_reg <= mslot_next;
        code_reg <= code_next; oid_reg <= oid_next; off_reg <= off_next;
        trim_reg <= trim_next; len_reg <= len_next;
        m_data_reg <= m_data_next;
    end

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= DEPTH_I) else $error("held count exceeds table depth");

    a_pending_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg == ready_reg + unack_reg) else $error("pending count mismatch");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("command accepted while busy");
endmodule
`default_nettype wire

// ===== tb/tb_ack_tracking_message_queue.sv =====
// Self-checking testbench for the acknowledged message queue. It predicts every
// result in order while it generates commands. Depends on acktq_pkg and the RTL top.
`timescale 1ns / 100ps
module tb_ack_tracking_message_queue;
    localparam int DEPTH = acktq_pkg::DEFAULT_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [acktq_pkg::OFF_W-1:0] OFF_MASK = '1;

    typedef logic [acktq_pkg::OP_W-1:0] opcode_t;

    typedef struct packed {
        logic [acktq_pkg::CODE_W-1:0] code;
        logic [acktq_pkg::ID_W-1:0]   out_id;
        logic [acktq_pkg::OFF_W-1:0]  offset;
        logic [acktq_pkg::SIZE_W-1:0] length;
        logic [acktq_pkg::OFF_W-1:0]  trimmed;
        logic [acktq_pkg::ID_W-1:0]   pending;
        logic [acktq_pkg::ID_W-1:0]   held;
    } queue_result_t;

    typedef struct packed {
        logic                         drain;
        logic [acktq_pkg::OP_W-1:0]   op;
        logic [acktq_pkg::ID_W-1:0]   id;
        logic [acktq_pkg::SIZE_W-1:0] size;
    } command_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // opcode[2:0], msg_id[34:3], msg_size[66:35], zero fill
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // result_code[1:0], out_id[33:2], data_offset[81:34], data_length[113:82],
    // trimmed_bytes[161:114], pending_count[193:162], held_count[225:194], zero fill
    logic [231:0] m_tdata;

    ack_tracking_message_queue uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Shadow copy of the queue table and its pointers.
    logic [acktq_pkg::ST_W-1:0]   q_state [DEPTH];
    logic [acktq_pkg::OFF_W-1:0]  q_offset [DEPTH];
    logic [acktq_pkg::SIZE_W-1:0] q_length [DEPTH];
    logic [acktq_pkg::ID_W-1:0]   next_id, oldest_id, ready_head, ack_ptr;
    logic [acktq_pkg::OFF_W-1:0]  data_end, offset_base;
    logic [acktq_pkg::ID_W-1:0]   held_total, pending_total, ready_total, unacked_total;

    command_t        cmd_queue [$];
    queue_result_t   expected_results [$];
    logic [acktq_pkg::ID_W-1:0] handed_out [$];
    int cycle_count, accepted_count, received_count, errors;
    int acks_done, nacks_done, purges_done, empties_seen, fulls_seen;
    bit stimulus_done;

    function automatic logic [acktq_pkg::ID_W-1:0] id_dist(logic [acktq_pkg::ID_W-1:0] id);
        return id - oldest_id;
    endfunction

    function automatic queue_result_t queue_step(opcode_t op,
                                                 logic [acktq_pkg::ID_W-1:0] id,
                                                 logic [acktq_pkg::SIZE_W-1:0] size);
        queue_result_t r;
        logic [acktq_pkg::OFF_W-1:0] first;
        int s;
        r = '0;
        r.code = acktq_pkg::RC_FAIL;
        if (op == acktq_pkg::OP_ENQ) begin
            if (held_total < DEPTH) begin
                s = next_id % DEPTH;
                q_state[s] = acktq_pkg::ST_READY;
                q_offset[s] = data_end;
                q_length[s] = size;
                r.out_id = next_id;
                next_id++;
                held_total++;
                pending_total++;
                ready_total++;
                data_end = data_end + size;
                r.code = acktq_pkg::RC_OK;
            end else begin
                fulls_seen++;
            end
        end else if (op == acktq_pkg::OP_DEQ) begin
            if (id_dist(ready_head) >= held_total) begin
                r.code = acktq_pkg::RC_EMPTY;
                empties_seen++;
            end else begin
                s = ready_head % DEPTH;
                r.out_id = ready_head;
                r.offset = (q_offset[s] - offset_base) & OFF_MASK;
                r.length = q_length[s];
                q_state[s] = acktq_pkg::ST_UNACK;
                ready_total--;
                unacked_total++;
                ready_head++;
                while (id_dist(ready_head) < held_total &&
                       q_state[ready_head % DEPTH] != acktq_pkg::ST_READY)
                    ready_head++;
                r.code = acktq_pkg::RC_OK;
            end
        end else if (op == acktq_pkg::OP_ACK || op == acktq_pkg::OP_FACK ||
                     op == acktq_pkg::OP_NACK) begin
            if (id_dist(id) < held_total && q_state[id % DEPTH] == acktq_pkg::ST_UNACK) begin
                s = id % DEPTH;
                unacked_total--;
                if (op == acktq_pkg::OP_NACK) begin
                    q_state[s] = acktq_pkg::ST_READY;
                    ready_total++;
                    if (id_dist(id) < id_dist(ready_head)) ready_head = id;
                    nacks_done++;
                end else begin
                    q_state[s] = (op == acktq_pkg::OP_ACK) ? acktq_pkg::ST_ACK
                                                           : acktq_pkg::ST_FACK;
                    pending_total--;
                    while (id_dist(ack_ptr) < held_total &&
                           (q_state[ack_ptr % DEPTH] == acktq_pkg::ST_ACK ||
                            q_state[ack_ptr % DEPTH] == acktq_pkg::ST_FACK))
                        ack_ptr++;
                    acks_done++;
                end
                r.code = acktq_pkg::RC_OK;
            end
        end else if (op == acktq_pkg::OP_PURGE) begin
            if (id_dist(ack_ptr) < held_total) begin
                first = q_offset[ack_ptr % DEPTH];
                r.trimmed = first - offset_base;
                offset_base = first;
                oldest_id = ack_ptr;
                held_total = next_id - oldest_id;
                pending_total = ready_total + unacked_total;
                purges_done++;
            end
            r.code = acktq_pkg::RC_OK;
        end
        r.pending = pending_total;
        r.held = held_total;
        return r;
    endfunction

    task automatic issue(opcode_t op, logic [acktq_pkg::ID_W-1:0] id,
                         logic [acktq_pkg::SIZE_W-1:0] size, bit drain = 0);
        queue_result_t r;
        r = queue_step(op, id, size);
        if (op == acktq_pkg::OP_DEQ && r.code == acktq_pkg::RC_OK) handed_out.push_back(r.out_id);
        cmd_queue.push_back({drain, op, id, size});
        expected_results.push_back(r);
    endtask

    // Mostly well-formed traffic: acks and nacks aim at ids that were handed out.
    task automatic random_command();
        int w, k;
        logic [acktq_pkg::ID_W-1:0] id;
        w = $urandom_range(99);
        id = $urandom;
        if (handed_out.size() > 0 && $urandom_range(9) != 0) begin
            k = $urandom_range(handed_out.size() - 1);
            id = handed_out[k];
            handed_out.delete(k);
        end
        if (w < 30)      issue(acktq_pkg::OP_ENQ, $urandom,
                               $urandom_range(4) == 0 ? $urandom : $urandom_range(4095));
        else if (w < 55) issue(acktq_pkg::OP_DEQ, $urandom, $urandom);
        else if (w < 70) issue(acktq_pkg::OP_ACK, id, $urandom);
        else if (w < 75) issue(acktq_pkg::OP_FACK, id, $urandom);
        else if (w < 82) issue(acktq_pkg::OP_NACK, id, $urandom);
        else if (w < 90) issue(acktq_pkg::OP_PURGE, $urandom, $urandom);
        else             issue(opcode_t'($urandom_range(7)), $urandom, $urandom);
    endtask

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        aresetn = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            q_state[i] = acktq_pkg::ST_READY;
            q_offset[i] = '0;
            q_length[i] = '0;
        end
        {next_id, oldest_id, ready_head, ack_ptr} = '0;
        {data_end, offset_base} = '0;
        {held_total, pending_total, ready_total, unacked_total} = '0;
        {acks_done, nacks_done, purges_done, empties_seen, fulls_seen} = '0;

        // Directed: field extremes, every opcode and each corner case.
        issue(acktq_pkg::OP_ENQ, 32'h0, 32'h0);
        issue(acktq_pkg::OP_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(acktq_pkg::OP_ENQ, 32'h5555_5555, 32'hAAAA_AAAA);
        issue(acktq_pkg::OP_DEQ, 0, 0);
        issue(acktq_pkg::OP_DEQ, 0, 0);
        issue(acktq_pkg::OP_DEQ, 0, 0);
        issue(acktq_pkg::OP_DEQ, 0, 0);
        issue(acktq_pkg::OP_ACK, 0, 0);
        issue(acktq_pkg::OP_ACK, 0, 0);
        issue(acktq_pkg::OP_FACK, 1, 0);
        issue(acktq_pkg::OP_NACK, 2, 0);
        issue(acktq_pkg::OP_NACK, 2, 0);
        issue(acktq_pkg::OP_DEQ, 0, 0);
        issue(acktq_pkg::OP_ACK, 32'hFFFF_FFFF, 0);
        issue(acktq_pkg::OP_NACK, 7, 0);
        issue(acktq_pkg::OP_PURGE, 0, 0);
        issue(opcode_t'(6), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(opcode_t'(7), 0, 0);
        issue(acktq_pkg::OP_ACK, 2, 0);
        issue(acktq_pkg::OP_PURGE, 0, 0);
        issue(acktq_pkg::OP_PURGE, 0, 0);
        issue(acktq_pkg::OP_DEQ, 0, 0);
        handed_out.delete();

        repeat (250) random_command();
        // Pause the sender until everything has drained, then fill the table past full.
        issue(acktq_pkg::OP_ENQ, 0, $urandom, 1);
        while (held_total < DEPTH) issue(acktq_pkg::OP_ENQ, $urandom, $urandom_range(255));
        repeat (3) issue(acktq_pkg::OP_ENQ, $urandom, $urandom);
        repeat (120) random_command();
        stimulus_done = 1;
    end

    // Command driver.
    always @(posedge aclk) begin
        command_t c;
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready) accepted_count++;
            if (!(s_tvalid && !s_tready)) begin
                if (cmd_queue.size() > 0 &&
                    (!cmd_queue[0].drain || (!s_tvalid && received_count == accepted_count)) &&
                    ((cycle_count >= 5000 && cycle_count < 8000) || $urandom_range(99) >= 13)) begin
                    c = cmd_queue.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= {5'b0, c.size, c.id, c.op};
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // Result monitor and receiver backpressure.
    always @(posedge aclk) begin
        queue_result_t e, a;
        cycle_count++;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (cycle_count >= 2500 && cycle_count < 2800)
                m_tready <= 0;
            else
                m_tready <= (cycle_count >= 5000 && cycle_count < 8000) ||
                            $urandom_range(99) >= 13;
            if (m_tvalid && m_tready) begin
                received_count++;
                a = {m_tdata[1:0], m_tdata[33:2], m_tdata[81:34], m_tdata[113:82],
                     m_tdata[161:114], m_tdata[193:162], m_tdata[225:194]};
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transaction %h", $time, a);
                end else begin
                    e = expected_results.pop_front();
                    if (a.code != e.code) begin
                        errors++;
                        $display("%0t: result_code expected %0d actual %0d", $time, e.code, a.code);
                    end
                    if (a.out_id != e.out_id) begin
                        errors++;
                        $display("%0t: out_id expected %h actual %h", $time, e.out_id, a.out_id);
                    end
                    if (a.offset != e.offset) begin
                        errors++;
                        $display("%0t: data_offset expected %h actual %h", $time, e.offset, a.offset);
                    end
                    if (a.length != e.length) begin
                        errors++;
                        $display("%0t: data_length expected %h actual %h", $time, e.length, a.length);
                    end
                    if (a.trimmed != e.trimmed) begin
                        errors++;
                        $display("%0t: trimmed_bytes expected %h actual %h",
                                 $time, e.trimmed, a.trimmed);
                    end
                    if (a.pending != e.pending) begin
                        errors++;
                        $display("%0t: pending_count expected %0d actual %0d",
                                 $time, e.pending, a.pending);
                    end
                    if (a.held != e.held) begin
                        errors++;
                        $display("%0t: held_count expected %0d actual %0d", $time, e.held, a.held);
                    end
                end
            end
        end
    end

    // End of run and timeout.
    initial begin
        bit done;
        done = 0;
        while (!done) begin
            @(posedge aclk);
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
            done = stimulus_done && cmd_queue.size() == 0 && !s_tvalid &&
                   received_count == accepted_count;
        end
        repeat (40) @(posedge aclk);
        if (expected_results.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end
        $display("Checked %0d results: %0d acks, %0d nacks, %0d purges, %0d empty, %0d full.",
                 received_count, acks_done, nacks_done, purges_done, empties_seen, fulls_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
